/* hw/rtl/tmsa_pkg.sv */
// ----------------------------------------------------------------------------
// tmsa_pkg
// Shared types and constants for the trimmed-mean sample averager.
// ----------------------------------------------------------------------------
`default_nettype none

package tmsa_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned SumW     = 32;
  localparam int unsigned DivSteps = SampleW;   // quotient always fits a sample
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [SampleW-1:0] MinBlock    = SampleW'(3);
  localparam logic [SampleW-1:0] CountReset  = SampleW'(16);
  localparam logic [SampleW-1:0] SmallestRst = {SampleW{1'b1}};

  typedef enum logic [1:0] {
    StIdle,
    StPrep,
    StDiv,
    StFin
  } tmsa_state_e;

  // controller -> datapath
  typedef struct packed {
    logic acc_en;    // accumulate the accepted sample
    logic load_div;  // form trimmed sum, seed divider, clear block
    logic step_en;   // one restoring division step
    logic out_load;  // capture quotient into output register
  } tmsa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_last;   // the sample on the input closes the block
  } tmsa_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/trimmed_mean_sample_averager_core.sv */
// ----------------------------------------------------------------------------
// trimmed_mean_sample_averager_core
// Olympic average of 16-bit samples: block mean with one max and one min cut.
// ----------------------------------------------------------------------------
// A sample beat that does not close a block is absorbed and the next beat
// may follow at once. After the beat that closes a block no sample is taken
// until its sequence ends: the beat is folded in, the trimmed sum is formed,
// the radix-2 restoring divider runs (one quotient bit a cycle), and the
// quotient moves into the output register; that last step waits
// while an earlier mean beat is still stalled. The block length comes from
// cfg_we_i/cfg_data_i (reset 16, values below 3 act as 3); a new length
// applies at once and the divisor is always samples actually taken minus two.
// ----------------------------------------------------------------------------
`default_nettype none

module trimmed_mean_sample_averager_core
  import tmsa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration: block length
  input  wire logic               cfg_we_i,
  input  wire logic [SampleW-1:0] cfg_data_i,
  // sample beats in
  input  wire logic               sample_valid_i,
  output logic                    sample_stall_o,
  input  wire logic [SampleW-1:0] sample_i,
  // mean beats out
  output logic                    mean_valid_o,
  input  wire logic               mean_stall_i,
  output logic      [SampleW-1:0] mean_o
);

  tmsa_cmd_t cmd;
  tmsa_sts_t sts;

  // sequencer: owns handshakes and divider step count
  tmsa_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .mean_valid_o   (mean_valid_o),
    .mean_stall_i   (mean_stall_i),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  // accumulators, divider and output register
  tmsa_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .mean_o     (mean_o)
  );

  // at most one datapath command a cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.acc_en, cmd.load_div, cmd.step_en, cmd.out_load}))
    else $error("tmsa: overlapping datapath commands");

  // a closing beat puts the block into the busy divide sequence
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_valid_i && !sample_stall_o && sts.is_last) |=> sample_stall_o)
    else $error("tmsa: input not stalled after block end");

  // a new mean only appears at the end of a divide sequence
  a_mean_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!mean_valid_o ##1 mean_valid_o) |-> $past(sample_stall_o))
    else $error("tmsa: mean presented without a division");

endmodule

`default_nettype wire

/* hw/rtl/tmsa_ctrl.sv */
// ----------------------------------------------------------------------------
// tmsa_ctrl
// Sequencer: sample acceptance, divider stepping and output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module tmsa_ctrl
  import tmsa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      sample_valid_i,
  output logic           sample_stall_o,
  output logic           mean_valid_o,
  input  wire logic      mean_stall_i,
  input  wire tmsa_sts_t sts_i,
  output tmsa_cmd_t      cmd_o
);

  tmsa_state_e        state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               out_free;
  logic               accept;

  assign out_free = !out_valid_q || !mean_stall_i;
  assign accept   = sample_valid_i && (state_q == StIdle);

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (accept && sts_i.is_last) state_d = StPrep;
      end
      StPrep: begin
        cnt_d   = '0;
        state_d = StDiv;
      end
      StDiv: begin
        cnt_d = cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivSteps - 1)) state_d = StFin;
      end
      StFin: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    sample_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        sample_stall_o = 1'b0;
        cmd_o.acc_en   = sample_valid_i;
      end
      StPrep: cmd_o.load_div = 1'b1;
      StDiv:  cmd_o.step_en  = 1'b1;
      StFin:  cmd_o.out_load = out_free;
      default: sample_stall_o = 1'b1;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !mean_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  assign mean_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tmsa_dp.sv */
// ----------------------------------------------------------------------------
// tmsa_dp
// Datapath: block accumulators, trimmed sum, radix-2 divider, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmsa_dp
  import tmsa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [SampleW-1:0] cfg_data_i,
  input  wire logic [SampleW-1:0] sample_i,
  input  wire tmsa_cmd_t          cmd_i,
  output tmsa_sts_t               sts_o,
  output logic      [SampleW-1:0] mean_o
);

  logic [SampleW-1:0] count_q;
  logic [SumW-1:0]    sum_q;
  logic [SampleW-1:0] max_q, min_q, taken_q;
  logic [SampleW-1:0] dvsr_q, rem_q, quo_q, mean_q;

  logic [SampleW-1:0] limit;
  logic [SampleW:0]   taken_nx;
  logic [SampleW:0]   taken_m2;
  logic [SumW-1:0]    rest;
  logic [SampleW:0]   trial, diff;
  logic               ge;

  // counts below three behave as three
  assign limit    = (count_q < MinBlock) ? MinBlock : count_q;
  assign taken_nx = {1'b0, taken_q} + (SampleW+1)'(1);
  assign taken_m2 = taken_nx - (SampleW+1)'(2);
  assign sts_o.is_last = (taken_nx >= {1'b0, limit});

  assign rest  = sum_q - (SumW'(max_q) + SumW'(min_q));
  assign trial = {rem_q, quo_q[SampleW-1]};
  assign diff  = trial - {1'b0, dvsr_q};
  assign ge    = (trial >= {1'b0, dvsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
      sum_q   <= '0;
      max_q   <= '0;
      min_q   <= SmallestRst;
      taken_q <= '0;
    end else begin
      if (cfg_we_i) count_q <= cfg_data_i;
      if (cmd_i.acc_en) begin
        sum_q <= sum_q + SumW'(sample_i);
        if (sample_i > max_q) max_q <= sample_i;
        if (sample_i < min_q) min_q <= sample_i;
        // last sample leaves the count; the clear follows in load_div
        if (!sts_o.is_last) taken_q <= taken_nx[SampleW-1:0];
      end
      if (cmd_i.load_div) begin
        sum_q   <= '0;
        max_q   <= '0;
        min_q   <= SmallestRst;
        taken_q <= '0;
      end
    end
  end

  // divider: quotient < 2^16, so the top half seeds the partial remainder
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) dvsr_q <= taken_m2[SampleW-1:0];
    if (cmd_i.load_div) begin
      rem_q <= rest[SumW-1:SampleW];
      quo_q <= rest[SampleW-1:0];
    end
    if (cmd_i.step_en) begin
      rem_q <= ge ? diff[SampleW-1:0] : trial[SampleW-1:0];
      quo_q <= {quo_q[SampleW-2:0], ge};
    end
    if (cmd_i.out_load) mean_q <= quo_q;
  end

  assign mean_o = mean_q;

endmodule

`default_nettype wire
